### sv/fcu_pkg.sv
package fcu_pkg;

  localparam int SECTOR_COUNT  = 200;
  localparam int ENCODER_RANGE = 16384;
  localparam int SINE_ENTRIES  = 1024;

  localparam int SECTOR_W = $clog2(SECTOR_COUNT);
  localparam int ENC_W    = $clog2(ENCODER_RANGE);
  localparam int SINE_W   = $clog2(SINE_ENTRIES);
  localparam int QTR      = SINE_ENTRIES / 4;
  localparam int QTR_W    = SINE_W - 2;

  localparam int SECTOR_DIV      = 82;
  localparam int SECTOR_RECIP    = 12788;   // ceil(2^20 / 82), exact for 14-bit readings
  localparam int SECTOR_RECIP_SH = 20;
  localparam int RECIP_W         = 14;
  localparam int SCALE_W    = 8;                  // in-sector angle scale 256
  localparam int NUM_W      = ENC_W + SCALE_W;    // divider dividend width
  localparam int PARK_SH    = 12;                 // Park products scaled by 4096
  localparam int PWM_W      = 10;
  localparam int PWM_LIMIT  = 1023;
  localparam int TRIG_W     = 14;                 // signed, +-4096
  localparam int PROD_W     = 16 + TRIG_W;
  localparam int PH_W       = PROD_W + 1 - PARK_SH;
  localparam int CFG_W      = 10;

  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_POS = 2'd1;
  localparam logic [1:0] DIR_NEG = 2'd2;

  localparam logic CFG_SECTOR_OFFSET = 1'b0;
  localparam logic CFG_PHASE_LEAD    = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam longint unsigned PI_Q28 = 64'd843314857;

  typedef logic [12:0] qsin_tab_t [0:QTR];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave table, round(4096*sin), integer Taylor series in Q28
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    longint unsigned theta, th2, term;
    longint sum;
    for (int k = 0; k <= QTR; k++) begin
      theta = (PI_Q28 * longint'(k)) >> (SINE_W - 1);
      th2   = (theta * theta) >> 28;
      term  = theta;
      sum   = longint'(theta);
      for (int n = 1; n <= 12; n++) begin
        term = udiv((term * th2) >> 28, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      tab[k] = 13'((longint'(sum) + 32768) >>> 16);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GUESS,
    ST_SCAN,
    ST_CHECK,
    ST_SCAN2,
    ST_SPAN,
    ST_WAITA,
    ST_ANGLE,
    ST_TRIG,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } fcu_state_t;

  typedef struct packed {
    logic       cap_in;
    logic       load_wr;
    logic       div_start;
    logic       set_guess;
    logic       rd;
    logic       shift;
    logic       check;
    logic       set_angle;
    logic       set_trig;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } dp_stat_t;

endpackage

### sv/fcu_div.sv
module fcu_div
  import fcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [ENC_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [ENC_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [ENC_W:0]   shifted, trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    trial    = shifted - {1'b0, den};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den}) begin
        rem_nxt = trial[ENC_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[ENC_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/fcu_dp.sv
module fcu_dp
  import fcu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [SECTOR_W-1:0] in_table_index,
  input  logic [ENC_W-1:0]    in_table_angle,
  input  logic [ENC_W-1:0]    in_encoder_reading,
  input  logic signed [15:0]  in_iq_target,
  input  logic signed [15:0]  in_id_target,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [PWM_W-1:0]    out_pwm_a,
  output logic [1:0]          out_dir_a,
  output logic [PWM_W-1:0]    out_pwm_b,
  output logic [1:0]          out_dir_b,
  output logic [SECTOR_W-1:0] out_sector_found,
  output logic [SINE_W-1:0]   out_elec_angle
);

  function automatic logic [SECTOR_W-1:0] sec_inc(input logic [SECTOR_W-1:0] v);
    return (v == SECTOR_W'(SECTOR_COUNT - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [SECTOR_W-1:0] sec_dec(input logic [SECTOR_W-1:0] v);
    return (v == '0) ? SECTOR_W'(SECTOR_COUNT - 1) : v - 1'b1;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sine_at(input logic [SINE_W-1:0] x);
    logic [1:0]      quad;
    logic [QTR_W:0]  m;
    logic [QTR_W:0]  idx;
    logic [12:0]     v;
    quad = x[SINE_W-1 -: 2];
    m    = {1'b0, x[QTR_W-1:0]};
    idx  = quad[0] ? (QTR_W + 1)'(QTR) - m : m;
    v    = QSIN[idx];
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic [PWM_W+1:0] phase_out(input logic signed [PH_W-1:0] v);
    logic [PH_W-1:0] a;
    logic [1:0]      d;
    if (v > 0) begin
      a = v;
      d = DIR_POS;
    end else if (v < 0) begin
      a = -v;
      d = DIR_NEG;
    end else begin
      a = '0;
      d = DIR_OFF;
    end
    if (a > PH_W'(PWM_LIMIT)) a = PH_W'(PWM_LIMIT);
    return {d, a[PWM_W-1:0]};
  endfunction

  // calibration table
  logic [ENC_W-1:0] mem [0:SECTOR_COUNT-1];
  logic [ENC_W-1:0] rd_data_r;

  logic [SECTOR_W-1:0] offset_r;
  logic [SINE_W-1:0]   lead_r;
  logic [ENC_W-1:0]    r_r;
  logic signed [15:0]  iq_r, id_r;
  logic [SECTOR_W-1:0] cur_r, cur_nxt;
  logic [SECTOR_W-1:0] base_r, ptr_r, ptr_nxt;
  logic [ENC_W-1:0]    tabs_r [0:3];
  logic [SINE_W-1:0]   x_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;
  logic signed [PROD_W-1:0] prod_r [0:3];
  logic signed [PH_W-1:0]   ia_r, ib_r;
  logic                out_valid_r;
  logic [PWM_W-1:0]    pwm_a_r, pwm_b_r;
  logic [1:0]          dir_a_r, dir_b_r;
  logic [SECTOR_W-1:0] sec_out_r;
  logic [SINE_W-1:0]   elec_out_r;

  // divider, in-sector angle only
  logic             div_done;
  logic [NUM_W-1:0] div_quo, div_num;
  logic [ENC_W-1:0] div_den;
  logic [ENC_W-1:0] span, rel;

  assign span    = tabs_r[3] - tabs_r[2];
  assign rel     = r_r - tabs_r[2];
  assign div_num = {rel, {SCALE_W{1'b0}}};
  assign div_den = span;

  fcu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // reading/82 by reciprocal multiply
  logic [ENC_W+RECIP_W-1:0] rprod;
  logic [SECTOR_W-1:0]      r_sec;
  assign rprod = {{RECIP_W{1'b0}}, r_r} * (ENC_W + RECIP_W)'(SECTOR_RECIP);
  assign r_sec = rprod[SECTOR_RECIP_SH +: SECTOR_W];

  // sector guess: (reading/82 + offset) mod sector count
  logic [SECTOR_W:0]   gsum, gsub1, gsub2;
  logic [SECTOR_W-1:0] guess;
  always_comb begin
    gsum  = {1'b0, r_sec} + {1'b0, offset_r};
    gsub1 = (gsum >= (SECTOR_W + 1)'(SECTOR_COUNT)) ?
            gsum - (SECTOR_W + 1)'(SECTOR_COUNT) : gsum;
    gsub2 = (gsub1 >= (SECTOR_W + 1)'(SECTOR_COUNT)) ?
            gsub1 - (SECTOR_W + 1)'(SECTOR_COUNT) : gsub1;
    guess = gsub2[SECTOR_W-1:0];
  end

  // neighbor check, first match wins
  logic [SECTOR_W-1:0] cand [0:2];
  logic [2:0]          hit;
  always_comb begin
    cand[0] = base_r;
    cand[1] = sec_inc(base_r);
    cand[2] = sec_inc(cand[1]);
    for (int k = 0; k < 3; k++) begin
      hit[k] = (tabs_r[k] != tabs_r[k+1]) &&
               ((r_r - tabs_r[k]) <= (tabs_r[k+1] - tabs_r[k]));
    end
    if (hit[0]) cur_nxt = cand[0];
    else if (hit[1]) cur_nxt = cand[1];
    else if (hit[2]) cur_nxt = cand[2];
    else cur_nxt = cur_r;
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.set_guess) ptr_nxt = sec_dec(guess);
    else if (cmd.check) ptr_nxt = cur_nxt;
    else if (cmd.rd) ptr_nxt = sec_inc(ptr_r);
  end

  logic [SINE_W-1:0] angle;
  assign angle = (span == '0) ? '0 : div_quo[SINE_W-1:0];

  logic signed [15:0]       mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  always_comb begin
    case (cmd.mul_sel)
      2'd0: begin mul_a = id_r; mul_b = cos_r; end
      2'd1: begin mul_a = iq_r; mul_b = sin_r; end
      2'd2: begin mul_a = iq_r; mul_b = cos_r; end
      default: begin mul_a = id_r; mul_b = sin_r; end
    endcase
  end

  // Park sums, divided by 4096 truncating toward zero
  logic signed [PROD_W:0] sa, sb;
  always_comb begin
    sa = (PROD_W + 1)'(prod_r[0]) - (PROD_W + 1)'(prod_r[1]);
    sb = (PROD_W + 1)'(prod_r[2]) + (PROD_W + 1)'(prod_r[3]);
    if (sa < 0) sa = sa + (PROD_W + 1)'((1 << PARK_SH) - 1);
    if (sb < 0) sb = sb + (PROD_W + 1)'((1 << PARK_SH) - 1);
  end

  logic [PWM_W+1:0] pa, pb;
  assign pa = phase_out(ia_r);
  assign pb = phase_out(ib_r);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (in_table_index < SECTOR_W'(SECTOR_COUNT - 1) ||
                        in_table_index == SECTOR_W'(SECTOR_COUNT - 1)))
      mem[in_table_index] <= in_table_angle;
    if (cmd.rd) rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      r_r  <= in_encoder_reading;
      iq_r <= in_iq_target;
      id_r <= in_id_target;
    end
    if (cmd.set_guess) base_r <= sec_dec(guess);
    ptr_r <= ptr_nxt;
    if (cmd.shift) begin
      tabs_r[0] <= tabs_r[1];
      tabs_r[1] <= tabs_r[2];
      tabs_r[2] <= tabs_r[3];
      tabs_r[3] <= rd_data_r;
    end
    if (cmd.set_angle)
      x_r <= angle + {cur_r[1:0], {QTR_W{1'b0}}} + lead_r;
    if (cmd.set_trig) begin
      sin_r <= sine_at(x_r);
      cos_r <= sine_at(x_r + SINE_W'(QTR));
    end
    if (cmd.mul_en) prod_r[cmd.mul_sel] <= mul_a * mul_b;
    if (cmd.sum) begin
      ia_r <= PH_W'(sa >>> PARK_SH);
      ib_r <= PH_W'(sb >>> PARK_SH);
    end
    if (cmd.out_load) begin
      pwm_a_r    <= pa[PWM_W-1:0];
      dir_a_r    <= pa[PWM_W+1:PWM_W];
      pwm_b_r    <= pb[PWM_W-1:0];
      dir_b_r    <= pb[PWM_W+1:PWM_W];
      sec_out_r  <= cur_r;
      elec_out_r <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      lead_r      <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SECTOR_OFFSET) offset_r <= cfg_data[SECTOR_W-1:0];
      if (cfg_we && cfg_index == CFG_PHASE_LEAD) lead_r <= cfg_data[SINE_W-1:0];
      if (cmd.check) cur_r <= cur_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.out_full  = out_valid_r && !out_tready;

  assign out_valid        = out_valid_r;
  assign out_pwm_a        = pwm_a_r;
  assign out_dir_a        = dir_a_r;
  assign out_pwm_b        = pwm_b_r;
  assign out_dir_b        = dir_b_r;
  assign out_sector_found = sec_out_r;
  assign out_elec_angle   = elec_out_r;

endmodule

### sv/fcu_ctrl.sv
module fcu_ctrl
  import fcu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  fcu_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in  = 1'b1;
          cmd.load_wr = (in_action == ACT_LOAD);
          if (in_action == ACT_STEP) state_nxt = ST_GUESS;
        end
      end
      ST_GUESS: begin
        cmd.set_guess = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        // four reads, data lands in the next cycle
        cmd.rd    = (cnt_r < 3'd4);
        cmd.shift = (cnt_r != 3'd0);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 3'd4) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SCAN2;
      end
      ST_SCAN2: begin
        cmd.rd    = (cnt_r < 3'd2);
        cmd.shift = (cnt_r != 3'd0);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 3'd2) state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAITA;
      end
      ST_WAITA: begin
        if (stat.div_done) state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.set_angle = 1'b1;
        state_nxt     = ST_TRIG;
      end
      ST_TRIG: begin
        cmd.set_trig = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt_r[1:0];
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == 3'd3) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/encoder_calibrated_two_phase_foc_unit.sv
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: action; tdata: index, angle, reading, iq, id
// out_     out  out_tvalid/out_tready tdata: pwm_a, dir_a, pwm_b, dir_b, sector, elec angle
// cfg_     in   cfg_we (no wait)      cfg_index 0: sector offset, 1: phase lead
//
// A load request writes the table at the accept edge and the unit stays ready.
// A control request is finished before the next is taken; it runs through the
// 22-step restoring division for the in-sector angle, six table-port reads
// and four passes through the one Park multiplier; reading/82 is a
// reciprocal multiply in the guess cycle.
// rst_n (synchronous) clears control state, config and current sector;
// the calibration table is not cleared and reads garbage until loaded.
// The next request is taken while a result still sits in the output register;
// a stalled output only holds the engine in its final cycle.
module encoder_calibrated_two_phase_foc_unit
  import fcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [71:0]      in_tdata,   // table_index[7:0], table_angle[21:8],
                                       // encoder_reading[35:22], iq_target[51:36],
                                       // id_target[67:52], zero pad
  input  logic             in_tuser,   // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // pwm_a[9:0], dir_a[11:10], pwm_b[21:12],
                                       // dir_b[23:22], sector_found[31:24],
                                       // elec_angle[41:32], zero pad
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [PWM_W-1:0]    pwm_a, pwm_b;
  logic [1:0]          dir_a, dir_b;
  logic [SECTOR_W-1:0] sector_found;
  logic [SINE_W-1:0]   elec_angle;

  fcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcu_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_table_index     (in_tdata[7:0]),
    .in_table_angle     (in_tdata[21:8]),
    .in_encoder_reading (in_tdata[35:22]),
    .in_iq_target       (in_tdata[51:36]),
    .in_id_target       (in_tdata[67:52]),
    .out_tready         (out_tready),
    .out_valid          (out_tvalid),
    .out_pwm_a          (pwm_a),
    .out_dir_a          (dir_a),
    .out_pwm_b          (pwm_b),
    .out_dir_b          (dir_b),
    .out_sector_found   (sector_found),
    .out_elec_angle     (elec_angle)
  );

  assign out_tdata = {6'd0, elec_angle, sector_found, dir_b, pwm_b, dir_a, pwm_a};

endmodule
